// File: design/htesc_pkg.sv
// Package with the payload types, string tables and decimal powers of the HTML escaper.
package htesc_pkg;

   localparam int TAB_STOP = 8;
   localparam int COL_W = $clog2(TAB_STOP);
   localparam int CP_W = 21;
   localparam int STR_IDX_W = 3;
   localparam int DEC_IDX_W = 3;
   localparam int DEC_TOP = 6;

   localparam logic [1:0] MODE_PRE_BIT = 2'd0;
   localparam logic [1:0] MODE_NL_BIT = 2'd1;
   localparam logic [1:0] MODE_SP_BIT = 2'd2;

   localparam logic [CP_W-1:0] CP_TAB = 21'd9;
   localparam logic [CP_W-1:0] CP_LF = 21'd10;
   localparam logic [CP_W-1:0] CP_CR = 21'd13;
   localparam logic [CP_W-1:0] CP_SPACE = 21'd32;
   localparam logic [CP_W-1:0] CP_QUOT = 21'd34;
   localparam logic [CP_W-1:0] CP_AMP = 21'd38;
   localparam logic [CP_W-1:0] CP_LT = 21'd60;
   localparam logic [CP_W-1:0] CP_GT = 21'd62;
   localparam logic [CP_W-1:0] CP_PRINT_LO = 21'h20;
   localparam logic [CP_W-1:0] CP_PRINT_HI = 21'h80;

   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_LF = 8'h0A;
   localparam logic [7:0] BYTE_SEMI = 8'h3B;
   localparam logic [7:0] BYTE_ZERO = 8'h30;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            first_of_text;
      logic            last_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      STR_LT,
      STR_GT,
      STR_AMP,
      STR_QUOT,
      STR_NBSP,
      STR_BR,
      STR_PRE_OPEN,
      STR_PRE_CLOSE,
      STR_DEC_OPEN,
      STR_SPACE
   } str_id_type;

   function automatic logic [47:0] str_text(input str_id_type id);
      logic [47:0] s;
      case (id)
         STR_LT:        s = {"&lt;", 16'h0};
         STR_GT:        s = {"&gt;", 16'h0};
         STR_AMP:       s = {"&amp;", 8'h0};
         STR_QUOT:      s = "&quot;";
         STR_NBSP:      s = "&nbsp;";
         STR_BR:        s = {"<br>", 16'h0};
         STR_PRE_OPEN:  s = "<PRE>\n";
         STR_PRE_CLOSE: s = "</PRE>";
         STR_DEC_OPEN:  s = {"&#", 32'h0};
         STR_SPACE:     s = {" ", 40'h0};
         default:       s = 48'h0;
      endcase
      return s;
   endfunction

   function automatic logic [STR_IDX_W-1:0] str_last_idx(input str_id_type id);
      logic [STR_IDX_W-1:0] n;
      case (id)
         STR_LT:        n = 3'd3;
         STR_GT:        n = 3'd3;
         STR_AMP:       n = 3'd4;
         STR_QUOT:      n = 3'd5;
         STR_NBSP:      n = 3'd5;
         STR_BR:        n = 3'd3;
         STR_PRE_OPEN:  n = 3'd5;
         STR_PRE_CLOSE: n = 3'd5;
         STR_DEC_OPEN:  n = 3'd1;
         STR_SPACE:     n = 3'd0;
         default:       n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] str_byte(input str_id_type id,
                                           input logic [STR_IDX_W-1:0] idx);
      logic [47:0] s;
      s = str_text(id);
      return s[47 - 8 * idx -: 8];
   endfunction

   function automatic logic [CP_W-1:0] pow10(input logic [DEC_IDX_W-1:0] idx);
      logic [CP_W-1:0] p;
      case (idx)
         3'd0:    p = 21'd1;
         3'd1:    p = 21'd10;
         3'd2:    p = 21'd100;
         3'd3:    p = 21'd1000;
         3'd4:    p = 21'd10000;
         3'd5:    p = 21'd100000;
         3'd6:    p = 21'd1000000;
         default: p = 21'd1;
      endcase
      return p;
   endfunction

endpackage

// File: design/text_to_html_escaper_top.sv
// Top level of the HTML escaper: sequencer, decimal digit unit and output register.
//
// Each request carries one code point and produces zero or more HTML bytes, one byte per
// cycle at best, with last_byte set on the final byte of the request. The block takes one
// request at a time and holds req_stall high until the last byte of it has moved to the
// output register. A request passes through acceptance, the production of each byte, an end
// step that also writes a space still held at the end of a text, and a step that moves the
// last byte to the output register. A decimal character reference is produced by one shared
// compare-and-subtract unit that finds each digit by repeated subtraction of a power of ten
// and also spends a step on each leading zero it skips. A space with space conversion on
// that is neither first nor last of a text is held back until the next request. format_mode
// may only be written while no request is in progress.
module text_to_html_escaper_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  htesc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output htesc_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [2:0]                csr_write_data
);
   import htesc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_OPEN,
      S_HELD,
      S_BODY,
      S_CHAR,
      S_DIGIT,
      S_SEMI,
      S_TRAIL,
      S_CLOSE,
      S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      K_STR,
      K_TAB,
      K_NL,
      K_DEC
   } body_kind_type;

   state_type            state_ff, state_in;
   state_type            start_st_ff, start_st_in;
   body_kind_type        kind_ff, kind_in;
   str_id_type           body_str_ff, body_str_in;
   str_id_type           held_str_ff, held_str_in;
   logic [2:0]           mode_ff, mode_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic                 pend_ff, pend_in;
   logic                 held_ff, held_in;
   logic                 last_ff, last_in;
   logic [7:0]           ch_ff, ch_in;
   logic                 nl_ff, nl_in;
   logic [STR_IDX_W-1:0] idx_ff, idx_in;
   logic [CP_W-1:0]      rem_ff, rem_in;
   logic [DEC_IDX_W-1:0] pow_idx_ff, pow_idx_in;
   logic [3:0]           dig_ff, dig_in;
   logic                 started_ff, started_in;
   logic [7:0]           hold_ff, hold_in;
   logic                 hold_full_ff, hold_full_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   logic                 accept;
   logic                 step_ok;
   logic                 emit;
   logic [7:0]           emit_byte;
   str_id_type           cur_str;
   logic [7:0]           str_b;
   logic                 str_end;
   logic [COL_W-1:0]     col_next;
   logic [CP_W-1:0]      pow;
   logic [CP_W-1:0]      cp;
   logic                 first;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign cp = req_payload.code_point;
   assign first = req_payload.first_of_text;

   always_comb begin
      case (state_ff)
         S_OPEN:  cur_str = STR_PRE_OPEN;
         S_HELD:  cur_str = held_str_ff;
         S_BODY:  cur_str = body_str_ff;
         S_CLOSE: cur_str = STR_PRE_CLOSE;
         default: cur_str = STR_SPACE;
      endcase
   end

   assign str_b = str_byte(cur_str, idx_ff);
   assign str_end = (idx_ff == str_last_idx(cur_str));
   assign col_next = (col_ff == COL_W'(TAB_STOP - 1)) ? '0 : col_ff + 1'b1;
   assign pow = pow10(pow_idx_ff);
   assign step_ok = !hold_full_ff || !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      start_st_in = start_st_ff;
      kind_in = kind_ff;
      body_str_in = body_str_ff;
      held_str_in = held_str_ff;
      mode_in = mode_ff;
      col_in = col_ff;
      pend_in = pend_ff;
      held_in = held_ff;
      last_in = last_ff;
      ch_in = ch_ff;
      nl_in = nl_ff;
      idx_in = idx_ff;
      rem_in = rem_ff;
      pow_idx_in = pow_idx_ff;
      dig_in = dig_ff;
      started_in = started_ff;
      hold_in = hold_ff;
      hold_full_in = hold_full_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      emit = 1'b0;
      emit_byte = str_b;

      if (csr_write_enable) begin
         mode_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = req_payload.last_of_text;
               idx_in = '0;
               nl_in = 1'b0;
               ch_in = cp[7:0];
               kind_in = K_STR;
               body_str_in = STR_NBSP;
               rem_in = cp;
               pow_idx_in = DEC_IDX_W'(DEC_TOP);
               dig_in = '0;
               started_in = 1'b0;
               held_in = first ? 1'b0 : pend_ff;
               pend_in = 1'b0;
               if (first) begin
                  col_in = '0;
               end
               held_str_in = (cp == CP_SPACE || cp == CP_TAB) ? STR_NBSP : STR_SPACE;
               start_st_in = S_BODY;
               if (cp == CP_LT) begin
                  body_str_in = STR_LT;
               end else if (cp == CP_GT) begin
                  body_str_in = STR_GT;
               end else if (cp == CP_AMP) begin
                  body_str_in = STR_AMP;
               end else if (cp == CP_QUOT) begin
                  body_str_in = STR_QUOT;
               end else if (cp == CP_LF) begin
                  ch_in = BYTE_LF;
                  nl_in = 1'b1;
                  if (mode_ff[MODE_NL_BIT]) begin
                     kind_in = K_NL;
                     body_str_in = STR_BR;
                  end else begin
                     start_st_in = S_CHAR;
                  end
               end else if (cp == CP_TAB) begin
                  if (mode_ff[MODE_NL_BIT] || mode_ff[MODE_SP_BIT]) begin
                     kind_in = K_TAB;
                  end else begin
                     start_st_in = S_CHAR;
                  end
               end else if (cp == CP_SPACE) begin
                  if (!mode_ff[MODE_SP_BIT]) begin
                     start_st_in = S_CHAR;
                  end else if (!first) begin
                     pend_in = 1'b1;
                     start_st_in = S_TRAIL;
                  end
               end else if ((cp >= CP_PRINT_LO && cp < CP_PRINT_HI) || cp == CP_CR) begin
                  start_st_in = S_CHAR;
               end else begin
                  kind_in = K_DEC;
                  body_str_in = STR_DEC_OPEN;
               end
               if (first && mode_ff[MODE_PRE_BIT]) begin
                  state_in = S_OPEN;
               end else if (!first && pend_ff) begin
                  state_in = S_HELD;
               end else begin
                  state_in = start_st_in;
               end
            end
         end
         S_OPEN: begin
            if (step_ok) begin
               emit = 1'b1;
               if (str_end) begin
                  idx_in = '0;
                  state_in = held_ff ? S_HELD : start_st_ff;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_HELD: begin
            if (step_ok) begin
               emit = 1'b1;
               if (str_end) begin
                  idx_in = '0;
                  col_in = col_next;
                  state_in = start_st_ff;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_BODY: begin
            if (step_ok) begin
               emit = 1'b1;
               if (str_end) begin
                  idx_in = '0;
                  case (kind_ff)
                     K_STR: begin
                        col_in = col_next;
                        state_in = S_TRAIL;
                     end
                     K_TAB: begin
                        col_in = col_next;
                        if (col_next == '0) begin
                           state_in = S_TRAIL;
                        end
                     end
                     K_NL: state_in = S_CHAR;
                     K_DEC: state_in = S_DIGIT;
                     default: state_in = S_TRAIL;
                  endcase
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_CHAR: begin
            if (step_ok) begin
               emit = 1'b1;
               emit_byte = ch_ff;
               col_in = nl_ff ? '0 : col_next;
               state_in = S_TRAIL;
            end
         end
         S_DIGIT: begin
            if (step_ok) begin
               if (rem_ff >= pow) begin
                  rem_in = rem_ff - pow;
                  dig_in = dig_ff + 1'b1;
               end else begin
                  if (dig_ff != '0 || started_ff || pow_idx_ff == '0) begin
                     emit = 1'b1;
                     emit_byte = BYTE_ZERO + {4'h0, dig_ff};
                     started_in = 1'b1;
                  end
                  dig_in = '0;
                  if (pow_idx_ff == '0) begin
                     state_in = S_SEMI;
                  end else begin
                     pow_idx_in = pow_idx_ff - 1'b1;
                  end
               end
            end
         end
         S_SEMI: begin
            if (step_ok) begin
               emit = 1'b1;
               emit_byte = BYTE_SEMI;
               col_in = col_next;
               state_in = S_TRAIL;
            end
         end
         S_TRAIL: begin
            if (step_ok) begin
               if (last_ff && pend_ff) begin
                  emit = 1'b1;
                  emit_byte = BYTE_SPACE;
                  col_in = col_next;
                  pend_in = 1'b0;
               end
               state_in = (last_ff && mode_ff[MODE_PRE_BIT]) ? S_CLOSE : S_FLUSH;
            end
         end
         S_CLOSE: begin
            if (step_ok) begin
               emit = 1'b1;
               if (str_end) begin
                  idx_in = '0;
                  state_in = S_FLUSH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FLUSH: begin
            if (step_ok) begin
               if (hold_full_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_payload_in.out_byte = hold_ff;
                  rsp_payload_in.last_byte = 1'b1;
                  hold_full_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         if (hold_full_ff) begin
            rsp_valid_in = 1'b1;
            rsp_payload_in.out_byte = hold_ff;
            rsp_payload_in.last_byte = 1'b0;
         end
         hold_in = emit_byte;
         hold_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= '0;
         col_ff <= '0;
         pend_ff <= 1'b0;
         hold_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         col_ff <= col_in;
         pend_ff <= pend_in;
         hold_full_ff <= hold_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_st_ff <= start_st_in;
      kind_ff <= kind_in;
      body_str_ff <= body_str_in;
      held_str_ff <= held_str_in;
      held_ff <= held_in;
      last_ff <= last_in;
      ch_ff <= ch_in;
      nl_ff <= nl_in;
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      pow_idx_ff <= pow_idx_in;
      dig_ff <= dig_in;
      started_ff <= started_in;
      hold_ff <= hold_in;
      rsp_payload_ff <= rsp_payload_in;
   end

`ifndef ASSERT_OFF
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_full_ff)
      else $error("Held byte left over while idle.");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIGIT) |-> (dig_ff <= 4'd9))
      else $error("Decimal digit out of range.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("Request accepted without entering the busy state.");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(TAB_STOP - 1))
      else $error("Column out of range.");
`endif

endmodule
